[rtl/qprr_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package qprr_pkg;

  // Operand widths.
  localparam int unsigned WordW = 32;   // every port field and register
  localparam int unsigned DiffW = 33;   // landmark minus camera position
  localparam int unsigned QProdW = 34;  // quaternion product after the Q2.30 shift
  localparam int unsigned EntW = 37;    // matrix entry before saturation
  localparam int unsigned TermW = 35;   // one rotated term after the Q2.30 shift
  localparam int unsigned PosW = 37;    // camera-space coordinate and its magnitude
  localparam int unsigned FracW = 16;   // Q16.16 fraction bits
  localparam int unsigned NumW = PosW + FracW;  // dividend and quotient width
  localparam int unsigned LoW = 27;             // low slice of the quotient
  localparam int unsigned HiW = NumW - LoW;     // high slice of the quotient
  localparam int unsigned ProdW = NumW + WordW; // full scaled product
  localparam int unsigned ScaleW = 47;          // scaled value when in range
  localparam int unsigned ResW = 50;            // residual before saturation

  // Register indexes of the configuration port.
  localparam logic [1:0] RegFocal = 2'd0;
  localparam logic [1:0] RegCenterX = 2'd1;
  localparam logic [1:0] RegCenterY = 2'd2;

  localparam logic [WordW-1:0] FocalReset = 32'h0001_0000;

  // Pipeline stage positions.
  localparam int unsigned StQuat = 0;
  localparam int unsigned StMat = 1;
  localparam int unsigned StRot = 2;
  localparam int unsigned StSum = 3;
  localparam int unsigned StDiv0 = 4;
  localparam int unsigned StMulA = StDiv0 + NumW;
  localparam int unsigned StMulB = StMulA + 1;
  localparam int unsigned StOut = StMulB + 1;
  localparam int unsigned NumSt = StOut + 1;

  // Values that ride along beside the arithmetic.
  typedef struct packed {
    logic signed [WordW-1:0] seen_u;
    logic signed [WordW-1:0] seen_v;
    logic neg_u;
    logic neg_v;
    logic zero;
  } side_t;

  // One step of the two restoring dividers that share a divisor.
  typedef struct packed {
    logic [PosW-1:0] rem_u;
    logic [PosW-1:0] rem_v;
    logic [NumW-1:0] num_u;
    logic [NumW-1:0] num_v;
    logic [NumW-1:0] quo_u;
    logic [NumW-1:0] quo_v;
    logic [PosW-1:0] den;
    side_t side;
  } div_t;

endpackage

`default_nettype wire

[rtl/quaternion_pinhole_reprojection_residual.sv]
`timescale 1ns / 1ps
`default_nettype none

// Pinhole reprojection residual. Each request carries a unit quaternion
// (Q2.30, x,y,z,w), a camera position, a landmark and an observed pixel
// (all Q16.16). The block rotates the landmark offset into camera space,
// divides by depth, scales by the focal length, adds the principal point and
// returns predicted minus observed pixel for both axes, saturated to 32 bits,
// with a flag for zero depth or saturation. The pipeline is fully stalled
// only from the output end: one request enters every cycle unless the
// stalled pipeline is full. The longest part is the depth divider, a
// restoring divider that resolves one of the 53 quotient bits per stage;
// the quaternion products, the matrix, the rotation and the sums take
// four, and the two-slice focal multiply and output register take three
// more. Every stage holds its own valid bit, so bubbles close up while the
// output is stalled and a waiting result does not block new requests until
// the pipeline is full. Configuration registers are read live at the
// scaling stages and must only be written while the block is empty.
module quaternion_pinhole_reprojection_residual (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  // Configuration writes: index 0 focal length, 1 center x, 2 center y.
  input  wire logic          cfg_valid_i,
  output logic               cfg_ready_o,
  input  wire logic [1:0]    cfg_index_i,
  input  wire logic [31:0]   cfg_data_i,
  // Input request stream.
  input  wire logic          s_axis_tvalid,
  output logic               s_axis_tready,
  // From bit 0 up: quat_x, quat_y, quat_z, quat_w, cam_pos_x, cam_pos_y,
  // cam_pos_z, world_x, world_y, world_z, seen_u, seen_v (32 bits each).
  input  wire logic [383:0]  s_axis_tdata,
  // Result stream.
  output logic               m_axis_tvalid,
  input  wire logic          m_axis_tready,
  // From bit 0 up: resid_u, resid_v (32 bits each).
  output logic [63:0]        m_axis_tdata,
  // Bit 0: bad flag, set on zero depth or saturation.
  output logic [0:0]         m_axis_tuser
);

  localparam int unsigned NumSt = qprr_pkg::NumSt;
  localparam int unsigned NumW = qprr_pkg::NumW;
  localparam int unsigned PosW = qprr_pkg::PosW;

  // Configuration registers.
  logic [31:0] focal_q, cx_q, cy_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      focal_q <= qprr_pkg::FocalReset;
      cx_q <= '0;
      cy_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        qprr_pkg::RegFocal: focal_q <= cfg_data_i;
        qprr_pkg::RegCenterX: cx_q <= cfg_data_i;
        qprr_pkg::RegCenterY: cy_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Flow control. A stage may load when it is empty or when the stage after
  // it loads in the same cycle.
  logic [NumSt-1:0] vld_q, vld_d;
  logic [NumSt:0] adv;

  assign adv[NumSt] = m_axis_tready;

  genvar g;
  generate
    for (g = 0; g < NumSt; g++) begin : g_flow
      assign adv[g] = !vld_q[g] || adv[g+1];
      if (g == 0) begin : g_first
        assign vld_d[g] = adv[g] ? s_axis_tvalid : vld_q[g];
      end else begin : g_rest
        assign vld_d[g] = adv[g] ? vld_q[g-1] : vld_q[g];
      end
    end
  endgenerate

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign s_axis_tready = adv[0];
  assign m_axis_tvalid = vld_q[qprr_pkg::StOut];

  // Stage 1: landmark offset and the nine quaternion products.
  logic signed [31:0] qx, qy, qz, qw;
  logic signed [32:0] d_d [3];
  logic signed [63:0] qp [9];
  logic signed [32:0] d1_q [3];
  logic signed [33:0] qp1_q [9];
  logic signed [31:0] su1_q, sv1_q;

  assign qx = s_axis_tdata[31:0];
  assign qy = s_axis_tdata[63:32];
  assign qz = s_axis_tdata[95:64];
  assign qw = s_axis_tdata[127:96];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      d_d[j] = {s_axis_tdata[32*(7+j)+31], s_axis_tdata[32*(7+j) +: 32]}
             - {s_axis_tdata[32*(4+j)+31], s_axis_tdata[32*(4+j) +: 32]};
    end
    // Order: xx, yy, zz, xy, xz, yz, wx, wy, wz.
    qp[0] = qx * qx;
    qp[1] = qy * qy;
    qp[2] = qz * qz;
    qp[3] = qx * qy;
    qp[4] = qx * qz;
    qp[5] = qy * qz;
    qp[6] = qw * qx;
    qp[7] = qw * qy;
    qp[8] = qw * qz;
  end

  always_ff @(posedge clk_i) begin
    if (adv[qprr_pkg::StQuat]) begin
      d1_q <= d_d;
      for (int j = 0; j < 9; j++) begin
        qp1_q[j] <= qp[j][63:30];
      end
      su1_q <= s_axis_tdata[351:320];
      sv1_q <= s_axis_tdata[383:352];
    end
  end

  // Stage 2: rotation matrix entries, each saturated to 32 bits.
  function automatic logic signed [31:0] sat_ent(input logic signed [36:0] v);
    if (v > 37'sd2147483647) begin
      return 32'sh7FFF_FFFF;
    end else if (v < -37'sd2147483648) begin
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

  logic signed [36:0] one_q30;
  logic signed [36:0] xx, yy, zz, xy, xz, yz, wx, wy, wz;
  logic signed [31:0] ent_d [9];
  logic signed [31:0] ent2_q [9];
  logic signed [32:0] d2_q [3];
  logic signed [31:0] su2_q, sv2_q;

  assign one_q30 = 37'sd1073741824;
  assign xx = 37'(qp1_q[0]);
  assign yy = 37'(qp1_q[1]);
  assign zz = 37'(qp1_q[2]);
  assign xy = 37'(qp1_q[3]);
  assign xz = 37'(qp1_q[4]);
  assign yz = 37'(qp1_q[5]);
  assign wx = 37'(qp1_q[6]);
  assign wy = 37'(qp1_q[7]);
  assign wz = 37'(qp1_q[8]);

  always_comb begin
    ent_d[0] = sat_ent(one_q30 - ((yy + zz) <<< 1));
    ent_d[1] = sat_ent((xy - wz) <<< 1);
    ent_d[2] = sat_ent((xz + wy) <<< 1);
    ent_d[3] = sat_ent((xy + wz) <<< 1);
    ent_d[4] = sat_ent(one_q30 - ((xx + zz) <<< 1));
    ent_d[5] = sat_ent((yz - wx) <<< 1);
    ent_d[6] = sat_ent((xz - wy) <<< 1);
    ent_d[7] = sat_ent((yz + wx) <<< 1);
    ent_d[8] = sat_ent(one_q30 - ((xx + yy) <<< 1));
  end

  always_ff @(posedge clk_i) begin
    if (adv[qprr_pkg::StMat]) begin
      ent2_q <= ent_d;
      d2_q <= d1_q;
      su2_q <= su1_q;
      sv2_q <= sv1_q;
    end
  end

  // Stage 3: the nine rotated terms, each floored back to Q16.16.
  logic signed [64:0] rp [9];
  logic signed [34:0] term3_q [9];
  logic signed [31:0] su3_q, sv3_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        rp[3*i+j] = 65'(ent2_q[3*i+j]) * 65'(d2_q[j]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[qprr_pkg::StRot]) begin
      for (int j = 0; j < 9; j++) begin
        term3_q[j] <= rp[j][64:30];
      end
      su3_q <= su2_q;
      sv3_q <= sv2_q;
    end
  end

  // Stage 4: camera-space point, signs and magnitudes for the dividers.
  logic signed [PosW-1:0] p_d [3];
  logic [PosW-1:0] mag_u4_q, mag_v4_q, den4_q;
  qprr_pkg::side_t side4_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      p_d[i] = PosW'(term3_q[3*i]) + PosW'(term3_q[3*i+1]) + PosW'(term3_q[3*i+2]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[qprr_pkg::StSum]) begin
      mag_u4_q <= p_d[0][PosW-1] ? PosW'(-p_d[0]) : PosW'(p_d[0]);
      mag_v4_q <= p_d[1][PosW-1] ? PosW'(-p_d[1]) : PosW'(p_d[1]);
      den4_q <= p_d[2][PosW-1] ? PosW'(-p_d[2]) : PosW'(p_d[2]);
      side4_q.neg_u <= p_d[0][PosW-1] ^ p_d[2][PosW-1];
      side4_q.neg_v <= p_d[1][PosW-1] ^ p_d[2][PosW-1];
      side4_q.zero <= (p_d[2] == '0);
      side4_q.seen_u <= su3_q;
      side4_q.seen_v <= sv3_q;
    end
  end

  // Restoring dividers, one quotient bit per stage for both axes.
  qprr_pkg::div_t div_in [NumW];
  qprr_pkg::div_t div_q [NumW];

  generate
    for (g = 0; g < NumW; g++) begin : g_div
      qprr_pkg::div_t src;
      logic [PosW:0] tu, tv;
      logic geu, gev;

      if (g == 0) begin : g_load
        always_comb begin
          src.rem_u = '0;
          src.rem_v = '0;
          src.num_u = {mag_u4_q, {qprr_pkg::FracW{1'b0}}};
          src.num_v = {mag_v4_q, {qprr_pkg::FracW{1'b0}}};
          src.quo_u = '0;
          src.quo_v = '0;
          src.den = den4_q;
          src.side = side4_q;
        end
      end else begin : g_chain
        assign src = div_q[g-1];
      end

      assign tu = {src.rem_u, src.num_u[NumW-1]};
      assign tv = {src.rem_v, src.num_v[NumW-1]};
      assign geu = (tu >= {1'b0, src.den});
      assign gev = (tv >= {1'b0, src.den});

      always_comb begin
        div_in[g] = src;
        div_in[g].rem_u = geu ? PosW'(tu - {1'b0, src.den}) : tu[PosW-1:0];
        div_in[g].rem_v = gev ? PosW'(tv - {1'b0, src.den}) : tv[PosW-1:0];
        div_in[g].num_u = {src.num_u[NumW-2:0], 1'b0};
        div_in[g].num_v = {src.num_v[NumW-2:0], 1'b0};
        div_in[g].quo_u = {src.quo_u[NumW-2:0], geu};
        div_in[g].quo_v = {src.quo_v[NumW-2:0], gev};
      end

      always_ff @(posedge clk_i) begin
        if (adv[qprr_pkg::StDiv0 + g]) begin
          div_q[g] <= div_in[g];
        end
      end
    end
  endgenerate

  // Focal scaling, first half: the quotient in two slices times the focal
  // length.
  qprr_pkg::side_t side_a_q;
  logic [qprr_pkg::LoW+31:0] plo_u_q, plo_v_q;
  logic [qprr_pkg::HiW+31:0] phi_u_q, phi_v_q;
  logic [NumW-1:0] qu, qv;

  assign qu = div_q[NumW-1].quo_u;
  assign qv = div_q[NumW-1].quo_v;

  always_ff @(posedge clk_i) begin
    if (adv[qprr_pkg::StMulA]) begin
      plo_u_q <= qu[qprr_pkg::LoW-1:0] * focal_q;
      phi_u_q <= qu[NumW-1:qprr_pkg::LoW] * focal_q;
      plo_v_q <= qv[qprr_pkg::LoW-1:0] * focal_q;
      phi_v_q <= qv[NumW-1:qprr_pkg::LoW] * focal_q;
      side_a_q <= div_q[NumW-1].side;
    end
  end

  // Focal scaling, second half: combine the slices and test for a product
  // beyond 2^62, which can never land in range.
  logic [qprr_pkg::ProdW-1:0] prod_u, prod_v;
  logic ovf_u_d, ovf_v_d;
  logic [qprr_pkg::ScaleW-1:0] sc_u_q, sc_v_q;
  logic ovf_u_q, ovf_v_q;
  qprr_pkg::side_t side_b_q;

  assign prod_u = (qprr_pkg::ProdW'(phi_u_q) << qprr_pkg::LoW) + qprr_pkg::ProdW'(plo_u_q);
  assign prod_v = (qprr_pkg::ProdW'(phi_v_q) << qprr_pkg::LoW) + qprr_pkg::ProdW'(plo_v_q);
  assign ovf_u_d = (|prod_u[qprr_pkg::ProdW-1:63]) || (prod_u[62] && (|prod_u[61:0]));
  assign ovf_v_d = (|prod_v[qprr_pkg::ProdW-1:63]) || (prod_v[62] && (|prod_v[61:0]));

  always_ff @(posedge clk_i) begin
    if (adv[qprr_pkg::StMulB]) begin
      sc_u_q <= prod_u[62:16];
      sc_v_q <= prod_v[62:16];
      ovf_u_q <= ovf_u_d;
      ovf_v_q <= ovf_v_d;
      side_b_q <= side_a_q;
    end
  end

  // Output stage: apply the sign, add the principal point, subtract the
  // observation and saturate. Zero depth overrides everything.
  logic signed [qprr_pkg::ResW-1:0] ru_w, rv_w;
  logic [31:0] ru_d, rv_d;
  logic satu, satv;
  logic [31:0] resid_u_q, resid_v_q;
  logic bad_q;

  assign ru_w = (side_b_q.neg_u ? -qprr_pkg::ResW'(sc_u_q) : qprr_pkg::ResW'(sc_u_q))
              + qprr_pkg::ResW'(cx_q) - qprr_pkg::ResW'(side_b_q.seen_u);
  assign rv_w = (side_b_q.neg_v ? -qprr_pkg::ResW'(sc_v_q) : qprr_pkg::ResW'(sc_v_q))
              + qprr_pkg::ResW'(cy_q) - qprr_pkg::ResW'(side_b_q.seen_v);

  always_comb begin
    satu = 1'b1;
    satv = 1'b1;
    if (ovf_u_q) begin
      ru_d = side_b_q.neg_u ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else if (ru_w > 50'sd2147483647) begin
      ru_d = 32'h7FFF_FFFF;
    end else if (ru_w < -50'sd2147483648) begin
      ru_d = 32'h8000_0000;
    end else begin
      ru_d = ru_w[31:0];
      satu = 1'b0;
    end
    if (ovf_v_q) begin
      rv_d = side_b_q.neg_v ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else if (rv_w > 50'sd2147483647) begin
      rv_d = 32'h7FFF_FFFF;
    end else if (rv_w < -50'sd2147483648) begin
      rv_d = 32'h8000_0000;
    end else begin
      rv_d = rv_w[31:0];
      satv = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[qprr_pkg::StOut]) begin
      if (side_b_q.zero) begin
        resid_u_q <= 32'h7FFF_FFFF;
        resid_v_q <= 32'h7FFF_FFFF;
        bad_q <= 1'b1;
      end else begin
        resid_u_q <= ru_d;
        resid_v_q <= rv_d;
        bad_q <= satu || satv;
      end
    end
  end

  assign m_axis_tdata = {resid_v_q, resid_u_q};
  assign m_axis_tuser = bad_q;

endmodule

`default_nettype wire
